@@ hdl/br1_pkg.sv @@
// Shared types and constants for the byte-run-1 row decoder.
// No dependencies; every other file of the block imports this package.
package br1_pkg;

    // Default sizing, handed to the top-level parameters
    localparam int MAX_PLANES_DEF    = 8;
    localparam int MAX_ROW_BYTES_DEF = 65536;

    // Entries in the queue between the parser and the line tracker
    localparam int QUEUE_DEPTH = 4;

    // Configuration port geometry
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register indexes (byte address is 4 * index)
    typedef enum logic [1:0] {
        REG_COMPRESSED  = 2'd0,
        REG_ROW_BYTES   = 2'd1,
        REG_ROW_COUNT   = 2'd2,
        REG_PLANE_COUNT = 2'd3
    } t_reg_idx;

    // Register reset values
    localparam logic        RST_COMPRESSED  = 1'b0;
    localparam logic [16:0] RST_ROW_BYTES   = 17'd2;
    localparam logic [15:0] RST_ROW_COUNT   = 16'd1;
    localparam logic [3:0]  RST_PLANE_COUNT = 4'd1;

    // Control byte that does nothing
    localparam logic [7:0] CTRL_NOP = 8'd128;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic        compressed;
        logic [16:0] row_bytes;
        logic [15:0] row_count;
        logic [3:0]  plane_count;
    } t_cfg;

    // One decoded run, passed from the parser to the line tracker
    typedef struct packed {
        logic [7:0] pixel_byte;
        logic [7:0] repeat_count;
        logic       overrun;
        logic       line_end;
    } t_item;

endpackage

@@ hdl/br1_front.sv @@
// Byte parser: classifies body bytes (control, literal, repeat, skip) and
// tracks the fill of the current scan line. Depends on br1_pkg.
module br1_front #(
    parameter int MAX_ROW_BYTES = 65536
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_restart,
    input  br1_pkg::t_cfg  i_cfg,
    input  logic           i_accept,
    input  logic [7:0]     i_body_byte,
    output logic           o_item_valid,
    output br1_pkg::t_item o_item
);
    import br1_pkg::*;

    localparam int LW = $clog2(MAX_ROW_BYTES + 1);
    localparam int CW = (LW > 8) ? LW : 8;

    typedef enum logic [1:0] {
        PH_CTRL,
        PH_LIT,
        PH_REP,
        PH_SKIP
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [7:0]      r_run, n_run;
    logic [LW-1:0]   r_used, n_used;

    logic [LW-1:0]   w_eff;
    logic [LW-1:0]   w_left;
    logic            w_emit;
    logic            w_over;
    logic            w_skip;
    logic            w_lend;
    logic [7:0]      w_count;

    // Clamp the configured line length
    always_comb begin
        if (i_cfg.row_bytes == 17'd0) begin
            w_eff = LW'(1);
        end else if (i_cfg.row_bytes > 17'(MAX_ROW_BYTES)) begin
            w_eff = LW'(MAX_ROW_BYTES);
        end else begin
            w_eff = LW'(i_cfg.row_bytes);
        end
    end

    assign w_left = w_eff - r_used;

    // Classify the byte and work out the next parser state
    always_comb begin
        n_phase = r_phase;
        n_run   = r_run;
        n_used  = r_used;
        w_emit  = 1'b0;
        w_over  = 1'b0;
        w_skip  = 1'b0;
        w_count = 8'd1;
        if (!i_cfg.compressed) begin
            w_emit = 1'b1;
        end else begin
            case (r_phase)
                PH_CTRL: begin
                    if (!i_body_byte[7]) begin
                        n_run   = i_body_byte + 8'd1;
                        n_phase = PH_LIT;
                    end else if (i_body_byte != CTRL_NOP) begin
                        n_run   = 8'(9'd257 - {1'b0, i_body_byte});
                        n_phase = PH_REP;
                    end
                end
                PH_LIT: begin
                    w_emit  = 1'b1;
                    w_over  = (w_left == LW'(1)) && (r_run > 8'd1);
                    w_skip  = w_over;
                    n_run   = r_run - 8'd1;
                    n_phase = (r_run == 8'd1) ? PH_CTRL : PH_LIT;
                end
                PH_REP: begin
                    w_emit  = 1'b1;
                    w_over  = CW'(r_run) > CW'(w_left);
                    w_count = w_over ? 8'(w_left) : r_run;
                    n_run   = 8'd0;
                    n_phase = PH_CTRL;
                end
                PH_SKIP: begin
                    if (r_run != 8'd0) begin
                        n_run = r_run - 8'd1;
                    end
                    n_phase = (r_run <= 8'd1) ? PH_CTRL : PH_SKIP;
                end
                default: begin
                    n_phase = PH_CTRL;
                end
            endcase
        end

        // Advance line; next line starts at control byte or literal skip
        w_lend = w_emit && (CW'(w_count) == CW'(w_left));
        if (w_emit) begin
            if (w_lend) begin
                n_used  = '0;
                n_run   = 8'd0;
                n_phase = w_skip ? PH_SKIP : PH_CTRL;
            end else begin
                n_used = r_used + LW'(w_count);
            end
        end
    end

    // Hand the run to the queue
    assign o_item_valid        = i_accept && w_emit;
    assign o_item.pixel_byte   = i_body_byte;
    assign o_item.repeat_count = w_count;
    assign o_item.overrun      = w_over;
    assign o_item.line_end     = w_lend;

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_phase <= PH_CTRL;
            r_run   <= 8'd0;
            r_used  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_run   <= n_run;
            r_used  <= n_used;
        end
    end

endmodule

@@ hdl/br1_queue.sv @@
// Short queue of decoded runs between the parser and the line tracker.
// Depends on br1_pkg for the run type and depth.
module br1_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_flush,
    input  logic           i_wr,
    input  br1_pkg::t_item i_data,
    output logic           o_full,
    output logic           o_empty,
    input  logic           i_rd,
    output br1_pkg::t_item o_data
);
    import br1_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_item          r_mem [QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [NW-1:0]  r_count;
    logic           w_wr;
    logic           w_rd;

    assign o_full  = (r_count == NW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Store incoming runs
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + NW'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

endmodule

@@ hdl/br1_back.sv @@
// Line tracker: tags runs with row and plane, flags image end, drops runs
// after the image is complete, and holds the result register. Uses br1_pkg.
module br1_back #(
    parameter int MAX_PLANES = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_restart,
    input  br1_pkg::t_cfg  i_cfg,
    input  logic           i_q_empty,
    input  br1_pkg::t_item i_q_data,
    output logic           o_q_rd,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [7:0]     o_pixel_byte,
    output logic [7:0]     o_repeat_count,
    output logic [15:0]    o_row_index,
    output logic [2:0]     o_plane_index,
    output logic           o_line_end,
    output logic           o_image_end,
    output logic           o_overrun
);
    import br1_pkg::*;

    logic          r_out_valid;
    logic          r_finished;
    logic [2:0]    r_plane;
    logic [15:0]   r_row;

    logic [3:0]    w_eff_planes;
    logic [15:0]   w_eff_rows;
    logic [3:0]    w_plane_inc;
    logic [16:0]   w_row_inc;
    logic          w_plane_wrap;
    logic          w_row_done;
    logic          w_take;
    logic          w_load;
    logic          w_img_end;

    // Clamp plane and row counts
    always_comb begin
        if (i_cfg.plane_count == 4'd0) begin
            w_eff_planes = 4'd1;
        end else if (i_cfg.plane_count > 4'(MAX_PLANES)) begin
            w_eff_planes = 4'(MAX_PLANES);
        end else begin
            w_eff_planes = i_cfg.plane_count;
        end
    end

    assign w_eff_rows   = (i_cfg.row_count == 16'd0) ? 16'd1 : i_cfg.row_count;
    assign w_plane_inc  = {1'b0, r_plane} + 4'd1;
    assign w_row_inc    = {1'b0, r_row} + 17'd1;
    assign w_plane_wrap = w_plane_inc >= w_eff_planes;
    assign w_row_done   = w_row_inc >= {1'b0, w_eff_rows};
    assign w_img_end    = i_q_data.line_end && w_plane_wrap && w_row_done;

    // Take the head run when the result slot frees up, or drop it once done
    assign w_take = !i_q_empty && (r_finished || !r_out_valid || i_pop);
    assign w_load = w_take && !r_finished;
    assign o_q_rd = w_take;
    assign o_empty = !r_out_valid;

    // Line position and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_out_valid <= 1'b0;
            r_finished  <= 1'b0;
            r_plane     <= 3'd0;
            r_row       <= 16'd0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (w_load && i_q_data.line_end) begin
                if (w_plane_wrap) begin
                    r_plane <= 3'd0;
                    r_row   <= 16'(w_row_inc);
                    if (w_row_done) begin
                        r_finished <= 1'b1;
                    end
                end else begin
                    r_plane <= 3'(w_plane_inc);
                end
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_pixel_byte   <= i_q_data.pixel_byte;
            o_repeat_count <= i_q_data.repeat_count;
            o_row_index    <= r_row;
            o_plane_index  <= r_plane;
            o_line_end     <= i_q_data.line_end;
            o_image_end    <= w_img_end;
            o_overrun      <= i_q_data.overrun;
        end
    end

endmodule

@@ hdl/byterun1_row_decoder.sv @@
// Top level of the byte-run-1 row decoder: register file, parser, run queue
// and line tracker. Depends on br1_pkg, br1_front, br1_queue, br1_back.
//
//   channel   handshake             payload
//   -------   -------------------   --------------------------------------------
//   input     push / full           i_body_byte
//   result    empty / pop           o_pixel_byte o_repeat_count o_row_index
//                                   o_plane_index o_line_end o_image_end o_overrun
//   config    psel penable pwrite   paddr pwdata prdata (pready tied high)
//
// One body byte is taken per cycle while push is high and full low; control bytes
// and skipped literals give no result. Runs go via the run queue to the result
// register. full rises only when the four-entry run queue is full; empty stays
// low until the result register is popped. Reset is synchronous: parser at a
// control byte, line 0, plane 0. A register write restarts decoding the same way.
module byterun1_row_decoder #(
    parameter int MAX_PLANES    = br1_pkg::MAX_PLANES_DEF,
    parameter int MAX_ROW_BYTES = br1_pkg::MAX_ROW_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [7:0]                 i_body_byte,
    output logic                       empty,
    input  logic                       pop,
    output logic [7:0]                 o_pixel_byte,
    output logic [7:0]                 o_repeat_count,
    output logic [15:0]                o_row_index,
    output logic [2:0]                 o_plane_index,
    output logic                       o_line_end,
    output logic                       o_image_end,
    output logic                       o_overrun,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [br1_pkg::ADDR_W-1:0] paddr,
    input  logic [br1_pkg::DATA_W-1:0] pwdata,
    output logic [br1_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import br1_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_cfg_wr;
    logic     w_accept;
    logic     w_item_valid;
    t_item    w_item;
    logic     w_q_empty;
    logic     w_q_rd;
    t_item    w_q_data;

    assign pready   = 1'b1;
    assign w_idx    = t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_accept = push && !full;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.compressed  <= RST_COMPRESSED;
            r_cfg.row_bytes   <= RST_ROW_BYTES;
            r_cfg.row_count   <= RST_ROW_COUNT;
            r_cfg.plane_count <= RST_PLANE_COUNT;
        end else if (w_cfg_wr) begin
            case (w_idx)
                REG_COMPRESSED:  r_cfg.compressed  <= pwdata[0];
                REG_ROW_BYTES:   r_cfg.row_bytes   <= pwdata[16:0];
                REG_ROW_COUNT:   r_cfg.row_count   <= pwdata[15:0];
                REG_PLANE_COUNT: r_cfg.plane_count <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (w_idx)
            REG_COMPRESSED:  prdata = DATA_W'(r_cfg.compressed);
            REG_ROW_BYTES:   prdata = DATA_W'(r_cfg.row_bytes);
            REG_ROW_COUNT:   prdata = DATA_W'(r_cfg.row_count);
            REG_PLANE_COUNT: prdata = DATA_W'(r_cfg.plane_count);
            default:         prdata = '0;
        endcase
    end

    br1_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (w_cfg_wr),
        .i_cfg        (r_cfg),
        .i_accept     (w_accept),
        .i_body_byte  (i_body_byte),
        .o_item_valid (w_item_valid),
        .o_item       (w_item)
    );

    br1_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flush (w_cfg_wr),
        .i_wr    (w_item_valid),
        .i_data  (w_item),
        .o_full  (full),
        .o_empty (w_q_empty),
        .i_rd    (w_q_rd),
        .o_data  (w_q_data)
    );

    br1_back #(
        .MAX_PLANES (MAX_PLANES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_restart      (w_cfg_wr),
        .i_cfg          (r_cfg),
        .i_q_empty      (w_q_empty),
        .i_q_data       (w_q_data),
        .o_q_rd         (w_q_rd),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_pixel_byte   (o_pixel_byte),
        .o_repeat_count (o_repeat_count),
        .o_row_index    (o_row_index),
        .o_plane_index  (o_plane_index),
        .o_line_end     (o_line_end),
        .o_image_end    (o_image_end),
        .o_overrun      (o_overrun)
    );

endmodule
